// ===== rtl/pfr_pkg.sv =====
package pfr_pkg;

    localparam int WORD_COUNT = 7;
    localparam int MAX_WORDS = 7;
    localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [7:0] MIN_LEN = 8'(WORD_COUNT * 8);
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] HEADER_FIRST_RESET = 8'h55;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'hAA;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_SHORT   = 2'd2
    } status_t;

    typedef enum logic {
        CFG_HEADER_FIRST  = 1'b0,
        CFG_HEADER_SECOND = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_HUNT_FIRST  = 5'b00001,
        PH_HUNT_SECOND = 5'b00010,
        PH_LENGTH      = 5'b00100,
        PH_PAYLOAD     = 5'b01000,
        PH_CHECK       = 5'b10000
    } phase_t;

    typedef struct packed {
        status_t                     status;
        logic [MAX_WORDS-1:0][63:0]  words;
    } result_t;

    // Reflected CRC-8, one byte folded in bit by bit, LSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/pfr_byte_if.sv =====
interface pfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/pfr_cfg_if.sv =====
interface pfr_cfg_if;
    import pfr_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pfr_result_if.sv =====
interface pfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] pos_x_bits;
    logic [63:0] pos_y_bits;
    logic [63:0] pos_z_bits;
    logic [63:0] ori_x_bits;
    logic [63:0] ori_y_bits;
    logic [63:0] ori_z_bits;
    logic [63:0] ori_w_bits;

    modport source (
        output valid, output status,
        output pos_x_bits, output pos_y_bits, output pos_z_bits,
        output ori_x_bits, output ori_y_bits, output ori_z_bits, output ori_w_bits,
        input ready
    );
    modport sink (
        input valid, input status,
        input pos_x_bits, input pos_y_bits, input pos_z_bits,
        input ori_x_bits, input ori_y_bits, input ori_z_bits, input ori_w_bits,
        output ready
    );
endinterface

// ===== rtl/pfr_parser.sv =====
module pfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic [7:0]        hdr_first,
    input  logic [7:0]        hdr_second,
    input  logic              sink_free,
    output logic              item_taken,
    output logic              res_valid,
    output pfr_pkg::result_t  res
);
    import pfr_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;
    logic [7:0] crc_fed;
    logic       emits;
    logic       store_en;

    logic [7:0][7:0] word_store_reg [WORD_COUNT];

    assign emits = (phase_reg == PH_CHECK)
                || ((phase_reg == PH_LENGTH) && (item_byte < MIN_LEN));
    assign item_taken = item_valid && (sink_free || !emits);
    assign res_valid = item_taken && emits;
    assign crc_fed = crc8_feed(crc_reg, item_byte);
    assign count_inc = count_reg + 8'd1;
    assign store_en = item_taken && (phase_reg == PH_PAYLOAD) && (count_reg < MIN_LEN);

    always_comb
    begin
        phase_next = phase_reg;
        crc_next = crc_reg;
        length_next = length_reg;
        count_next = count_reg;
        res.status = STATUS_OK;
        res.words = '0;
        unique case (phase_reg)
            PH_HUNT_FIRST:
            begin
                if (item_byte == hdr_first)
                begin
                    crc_next = crc8_feed(8'd0, item_byte);
                    phase_next = PH_HUNT_SECOND;
                end
            end
            PH_HUNT_SECOND:
            begin
                if (item_byte == hdr_second)
                begin
                    crc_next = crc_fed;
                    phase_next = PH_LENGTH;
                end
                else if (item_byte == hdr_first)
                begin
                    crc_next = crc8_feed(8'd0, item_byte);
                end
                else
                begin
                    crc_next = 8'd0;
                    phase_next = PH_HUNT_FIRST;
                end
            end
            PH_LENGTH:
            begin
                crc_next = crc_fed;
                length_next = item_byte;
                count_next = 8'd0;
                res.status = STATUS_SHORT;
                phase_next = (item_byte < MIN_LEN) ? PH_HUNT_FIRST : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_fed;
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_HUNT_FIRST;
                res.status = (item_byte == crc_reg) ? STATUS_OK : STATUS_CRC_ERR;
                for (int j = 0; j < WORD_COUNT; j++)
                begin
                    res.words[j] = word_store_reg[j];
                end
            end
            default:
            begin
                phase_next = PH_HUNT_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_FIRST;
            crc_reg <= 8'd0;
            length_reg <= 8'd0;
            count_reg <= 8'd0;
        end
        else if (item_taken)
        begin
            phase_reg <= phase_next;
            crc_reg <= crc_next;
            length_reg <= length_next;
            count_reg <= count_next;
        end
    end

    // The payload bytes are written little-endian into the word store.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            word_store_reg[count_reg[WORD_IDX_W+2:3]][count_reg[2:0]] <= item_byte;
        end
    end

endmodule

// ===== rtl/pfr_out_stage.sv =====
module pfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  pfr_pkg::result_t  res,
    output logic              sink_free,
    pfr_result_if.source      frame
);
    import pfr_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign sink_free = !valid_reg || frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sink_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sink_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign frame.valid = valid_reg;
    assign frame.status = res_reg.status;
    assign frame.pos_x_bits = res_reg.words[0];
    assign frame.pos_y_bits = res_reg.words[1];
    assign frame.pos_z_bits = res_reg.words[2];
    assign frame.ori_x_bits = res_reg.words[3];
    assign frame.ori_y_bits = res_reg.words[4];
    assign frame.ori_z_bits = res_reg.words[5];
    assign frame.ori_w_bits = res_reg.words[6];

endmodule

// ===== rtl/pose_frame_receiver_crc8.sv =====
// Channel  Dir  Words                        Payload
// rx       in   one received serial byte     data_byte
// frame    out  one frame report             status, pos_*_bits, ori_*_bits
// cfg      in   one header register write    index, data
//
// One byte a cycle while no report stalls: a byte enters the input register
// and then passes the parser (phase, CRC-8, length and word store); at a short
// length or check byte its report lands in the output register as it is taken.
// A full output register stalls only bytes that would report; other bytes
// keep flowing. Reset returns the parser to header hunting and the headers
// to 0x55 and 0xAA; the word store is not cleared.
module pose_frame_receiver_crc8 (
    input  logic          clk,
    input  logic          rst_n,
    pfr_cfg_if.sink       cfg,
    pfr_byte_if.sink      rx,
    pfr_result_if.source  frame
);
    import pfr_pkg::*;

    logic [7:0] hdr_first_reg;
    logic [7:0] hdr_second_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       item_taken;
    logic       res_valid;
    logic       sink_free;
    result_t    res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg <= HEADER_FIRST_RESET;
            hdr_second_reg <= HEADER_SECOND_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HEADER_FIRST:  hdr_first_reg <= cfg.data;
                CFG_HEADER_SECOND: hdr_second_reg <= cfg.data;
                default:           hdr_first_reg <= hdr_first_reg;
            endcase
        end
    end

    assign rx.ready = !in_valid_reg || item_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.data_byte;
        end
    end

    pfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .hdr_first  (hdr_first_reg),
        .hdr_second (hdr_second_reg),
        .sink_free  (sink_free),
        .item_taken (item_taken),
        .res_valid  (res_valid),
        .res        (res)
    );

    pfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .sink_free (sink_free),
        .frame     (frame)
    );

    // A report is produced only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> sink_free)
        else $error("report produced while output register is full");

    // A held input byte that is not consumed stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !item_taken) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost while stalled");

    // A short-length report carries no words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && (frame.status == STATUS_SHORT)) |->
        ((frame.pos_x_bits == 64'd0) && (frame.ori_w_bits == 64'd0)))
        else $error("short-length report carries word data");

    // A report appears only after the parser consumed a reporting byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame.valid) |-> $past(res_valid))
        else $error("report without a reporting byte");

endmodule
